// ===== sv/assert_macros.svh =====
// Assertion macros for the port checker of the receive queue.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RLRQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rlrq_pkg.sv =====
// Package for the rate limited receive queue: widths, codes, structs.
// No dependencies; imported by every other file of the block except rlrq_desc_ram and assert_macros.svh.
package rlrq_pkg;

   localparam int QUEUE_DEPTH_DEF   = 32;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int CAP_W      = 21;
   localparam int NPB_W      = 40;
   localparam int BATCH_W    = 32;
   localparam int PAY_W      = 16;
   localparam int HDR_W      = 8;
   localparam int TAG_W      = 16;
   localparam int TIME_W     = 48;
   localparam int LEN_W      = 17;
   localparam int DELAY_W    = 41;
   localparam int KIND_W     = 2;
   localparam int BUDGET_W   = 58;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   localparam logic [CAP_W-1:0]    CAP_RESET   = 21'd65536;
   localparam logic [NPB_W-1:0]    NPB_RESET   = 40'd65536;
   localparam logic [BATCH_W-1:0]  BATCH_RESET = 32'd5000;
   localparam logic [BUDGET_W-1:0] BUDGET_MAX  = '1;
   localparam logic [DELAY_W-1:0]  WAKE_MAX    = '1;

   localparam logic MODE_ARRIVAL = 1'b0;
   localparam logic MODE_WAKEUP  = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_BUFFERED,
      KIND_DROPPED,
      KIND_DELIVERED,
      KIND_WAKEUP
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY,
      CSR_NS_PER_BYTE,
      CSR_BATCH_TIME,
      CSR_BOOTSTRAP
   } csr_index_type;

   typedef enum logic [2:0] {
      BOP_NONE,
      BOP_ELAPSED,
      BOP_SUB,
      BOP_MUL,
      BOP_ADD
   } budget_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADMIT,
      ST_WAKE_TIME,
      ST_WAKE_SUB,
      ST_CHECK,
      ST_READ,
      ST_ACCUM,
      ST_WAKE_REQ,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [CAP_W-1:0]   buffer_capacity_bytes;
      logic [NPB_W-1:0]   ns_per_byte;
      logic [BATCH_W-1:0] batch_time_ns;
      logic               bootstrap_mode;
   } cfg_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [HDR_W-1:0] hdr;
      logic [PAY_W-1:0] pay;
   } desc_type;

   typedef struct packed {
      budget_op_type     op;
      logic [TIME_W-1:0] now_time;
      logic [LEN_W-1:0]  len;
   } budget_ctrl_type;

   typedef struct packed {
      logic               within_batch;
      logic               wake_due;
      logic [DELAY_W-1:0] wake_delay;
   } budget_stat_type;

endpackage

// ===== sv/rlrq_if.sv =====
// Valid/ready channel interfaces of the receive queue: request, response, csr.
// Depends on rlrq_pkg.
interface rlrq_req_if;
   import rlrq_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [PAY_W-1:0]  payload_length;
   logic [HDR_W-1:0]  header_size;
   logic [TAG_W-1:0]  packet_tag;
   logic [TIME_W-1:0] now_time;
   modport source (output valid, mode, payload_length, header_size, packet_tag, now_time,
                   input ready);
   modport sink (input valid, mode, payload_length, header_size, packet_tag, now_time,
                 output ready);
endinterface

interface rlrq_rsp_if;
   import rlrq_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [TAG_W-1:0]   out_tag;
   logic [LEN_W-1:0]   packet_bytes;
   logic [DELAY_W-1:0] wake_delay_ns;
   logic               last;
   modport source (output valid, kind, out_tag, packet_bytes, wake_delay_ns, last,
                   input ready);
   modport sink (input valid, kind, out_tag, packet_bytes, wake_delay_ns, last,
                 output ready);
endinterface

interface rlrq_csr_if;
   import rlrq_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/rlrq_desc_ram.sv =====
// Descriptor memory: one write port, one registered read port.
// Depends on nothing.
module rlrq_desc_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 40
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/rlrq_budget_unit.sv =====
// Shared budget arithmetic: elapsed time, clamped subtract, cost multiply,
// saturating add and batch compare. Depends on rlrq_pkg.
module rlrq_budget_unit #(
   parameter int FRACTION_BITS = rlrq_pkg::FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rlrq_pkg::cfg_type         cfg,
   input  rlrq_pkg::budget_ctrl_type ctrl,
   output rlrq_pkg::budget_stat_type stat
);
   import rlrq_pkg::*;

   localparam int SUB_W   = TIME_W + FRACTION_BITS;
   localparam int CMP_W   = (SUB_W > BUDGET_W) ? SUB_W : BUDGET_W;
   localparam int WHOLE_W = BUDGET_W - FRACTION_BITS;
   localparam int PROD_W  = LEN_W + NPB_W;

   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [TIME_W-1:0]   last_wake_ff, last_wake_in;
   logic [TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic                advanced_ff, advanced_in;
   logic [PROD_W-1:0]   product_ff, product_in;

   logic [CMP_W-1:0]    sub_wide;
   logic [CMP_W-1:0]    budget_wide;
   logic                sub_over;
   logic [BUDGET_W-1:0] room;
   logic [BUDGET_W-1:0] prod_ext;
   logic [WHOLE_W-1:0]  whole;

   always_comb begin
      sub_wide    = CMP_W'({elapsed_ff, {FRACTION_BITS{1'b0}}});
      budget_wide = CMP_W'(budget_ff);
      sub_over    = sub_wide > CMP_W'(BUDGET_MAX);
      room        = BUDGET_MAX - budget_ff;
      prod_ext    = BUDGET_W'(product_ff);

      budget_in    = budget_ff;
      last_wake_in = last_wake_ff;
      elapsed_in   = elapsed_ff;
      advanced_in  = advanced_ff;
      product_in   = product_ff;

      case (ctrl.op)
         BOP_ELAPSED: begin
            advanced_in  = ctrl.now_time > last_wake_ff;
            elapsed_in   = ctrl.now_time - last_wake_ff;
            last_wake_in = ctrl.now_time;
         end
         BOP_SUB: begin
            if (advanced_ff) begin
               if (sub_over) begin
                  budget_in = '0;
               end else if (budget_wide > sub_wide) begin
                  budget_in = budget_ff - BUDGET_W'(sub_wide);
               end else begin
                  budget_in = '0;
               end
            end
         end
         BOP_MUL: begin
            product_in = PROD_W'(ctrl.len) * PROD_W'(cfg.ns_per_byte);
         end
         BOP_ADD: begin
            if (!cfg.bootstrap_mode) begin
               budget_in = (prod_ext > room) ? BUDGET_MAX : budget_ff + prod_ext;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      whole             = budget_ff[BUDGET_W-1:FRACTION_BITS];
      stat.within_batch = budget_ff <= BUDGET_W'({cfg.batch_time_ns, {FRACTION_BITS{1'b0}}});
      stat.wake_due     = |whole;
      stat.wake_delay   = (CMP_W'(whole) > CMP_W'(WAKE_MAX)) ? WAKE_MAX : DELAY_W'(whole);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff    <= '0;
         last_wake_ff <= '0;
      end else begin
         budget_ff    <= budget_in;
         last_wake_ff <= last_wake_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff  <= elapsed_in;
      advanced_ff <= advanced_in;
      product_ff  <= product_in;
   end
endmodule

// ===== sv/rlrq_seq.sv =====
// Sequencer: admission, queue pointers, drain loop and response words.
// Depends on rlrq_pkg, rlrq_if; drives rlrq_desc_ram and rlrq_budget_unit.
module rlrq_seq #(
   parameter int QUEUE_DEPTH = rlrq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rlrq_pkg::CAP_W-1:0]     capacity,
   rlrq_req_if.sink                       req_bus,
   rlrq_rsp_if.source                     rsp_bus,
   output logic                           ram_we,
   output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
   output rlrq_pkg::desc_type             ram_wdata,
   output logic                           ram_re,
   output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
   input  rlrq_pkg::desc_type             ram_rdata,
   output rlrq_pkg::budget_ctrl_type      bctrl,
   input  rlrq_pkg::budget_stat_type      bstat
);
   import rlrq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   seq_state_type state_ff, state_in;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] buffered_ff, buffered_in;
   logic             receiving_ff, receiving_in;

   logic [PAY_W-1:0]  pay_ff;
   logic [HDR_W-1:0]  hdr_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TAG_W-1:0]  cur_tag_ff;
   logic [LEN_W-1:0]  cur_len_ff;

   logic               pend_valid_ff;
   kind_type           pend_kind_ff;
   logic [TAG_W-1:0]   pend_tag_ff;
   logic [LEN_W-1:0]   pend_bytes_ff;
   logic [DELAY_W-1:0] pend_delay_ff;

   logic               rsp_valid_ff;
   kind_type           rsp_kind_ff;
   logic [TAG_W-1:0]   rsp_tag_ff;
   logic [LEN_W-1:0]   rsp_bytes_ff;
   logic [DELAY_W-1:0] rsp_delay_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               can_emit;
   logic [CAP_W-1:0]   space;
   logic               admit;
   logic [CNT_W:0]     slot_sum;
   logic [IDX_W-1:0]   slot;
   logic [IDX_W-1:0]   head_next;
   logic [LEN_W-1:0]   deq_len;
   logic               more;
   logic               accept;

   logic               gen;
   kind_type           gen_kind;
   logic [TAG_W-1:0]   gen_tag;
   logic [LEN_W-1:0]   gen_bytes;
   logic [DELAY_W-1:0] gen_delay;
   logic               flush;
   logic               push;
   logic               do_enq;
   logic               do_deq;
   logic               recv_set;
   logic               recv_clr;
   budget_op_type      bop;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_bus.ready;
      can_emit  = !pend_valid_ff || out_free;
      space     = (capacity > buffered_ff) ? capacity - buffered_ff : '0;
      admit     = (count_ff < CNT_W'(QUEUE_DEPTH)) && (CAP_W'(pay_ff) <= space);
      slot_sum  = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
      slot      = (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                  ? IDX_W'(slot_sum - (CNT_W+1)'(QUEUE_DEPTH)) : IDX_W'(slot_sum);
      head_next = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
      deq_len   = LEN_W'(ram_rdata.pay) + LEN_W'(ram_rdata.hdr);
      more      = (count_ff != '0) && bstat.within_batch;
      accept    = req_bus.valid && req_bus.ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = (req_bus.mode == MODE_WAKEUP) ? ST_WAKE_TIME : ST_ADMIT;
            end
         end
         ST_ADMIT: begin
            if (can_emit) begin
               state_in = (admit && !receiving_ff) ? ST_CHECK : ST_FINISH;
            end
         end
         ST_WAKE_TIME: state_in = ST_WAKE_SUB;
         ST_WAKE_SUB:  state_in = ST_CHECK;
         ST_CHECK:     state_in = more ? ST_READ : ST_WAKE_REQ;
         ST_READ:      state_in = ST_ACCUM;
         ST_ACCUM: begin
            if (can_emit) begin
               state_in = ST_CHECK;
            end
         end
         ST_WAKE_REQ: begin
            if (!bstat.wake_due || can_emit) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_bus.ready = 1'b0;
      gen           = 1'b0;
      gen_kind      = KIND_BUFFERED;
      gen_tag       = '0;
      gen_bytes     = '0;
      gen_delay     = '0;
      flush         = 1'b0;
      do_enq        = 1'b0;
      do_deq        = 1'b0;
      recv_set      = 1'b0;
      recv_clr      = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      bop           = BOP_NONE;
      case (state_ff)
         ST_IDLE: req_bus.ready = !reset;
         ST_ADMIT: begin
            if (can_emit) begin
               gen      = 1'b1;
               gen_kind = admit ? KIND_BUFFERED : KIND_DROPPED;
               gen_tag  = tag_ff;
               do_enq   = admit;
               ram_we   = admit;
            end
         end
         ST_WAKE_TIME: begin
            bop      = BOP_ELAPSED;
            recv_clr = 1'b1;
         end
         ST_WAKE_SUB: bop = BOP_SUB;
         ST_CHECK:    ram_re = more;
         ST_READ: begin
            bop    = BOP_MUL;
            do_deq = 1'b1;
         end
         ST_ACCUM: begin
            if (can_emit) begin
               gen       = 1'b1;
               gen_kind  = KIND_DELIVERED;
               gen_tag   = cur_tag_ff;
               gen_bytes = cur_len_ff;
               bop       = BOP_ADD;
            end
         end
         ST_WAKE_REQ: begin
            if (bstat.wake_due && can_emit) begin
               gen       = 1'b1;
               gen_kind  = KIND_WAKEUP;
               gen_delay = bstat.wake_delay;
               recv_set  = 1'b1;
            end
         end
         ST_FINISH: flush = pend_valid_ff && out_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      push         = (gen && pend_valid_ff) || flush;
      head_in      = head_ff;
      count_in     = count_ff;
      buffered_in  = buffered_ff;
      receiving_in = receiving_ff;
      if (do_enq) begin
         count_in    = count_ff + CNT_W'(1);
         buffered_in = buffered_ff + CAP_W'(pay_ff);
      end
      if (do_deq) begin
         head_in     = head_next;
         count_in    = count_ff - CNT_W'(1);
         buffered_in = (buffered_ff >= CAP_W'(ram_rdata.pay))
                       ? buffered_ff - CAP_W'(ram_rdata.pay) : '0;
      end
      if (recv_clr) begin
         receiving_in = 1'b0;
      end
      if (recv_set) begin
         receiving_in = 1'b1;
      end
   end

   assign ram_waddr     = slot;
   assign ram_wdata.tag = tag_ff;
   assign ram_wdata.hdr = hdr_ff;
   assign ram_wdata.pay = pay_ff;
   assign ram_raddr     = head_ff;

   assign bctrl.op       = bop;
   assign bctrl.now_time = now_ff;
   assign bctrl.len      = deq_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         buffered_ff   <= '0;
         receiving_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         buffered_ff  <= buffered_in;
         receiving_ff <= receiving_in;
         if (gen) begin
            pend_valid_ff <= 1'b1;
         end else if (flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pay_ff <= req_bus.payload_length;
         hdr_ff <= req_bus.header_size;
         tag_ff <= req_bus.packet_tag;
         now_ff <= req_bus.now_time;
      end
      if (do_deq) begin
         cur_tag_ff <= ram_rdata.tag;
         cur_len_ff <= deq_len;
      end
      if (gen) begin
         pend_kind_ff  <= gen_kind;
         pend_tag_ff   <= gen_tag;
         pend_bytes_ff <= gen_bytes;
         pend_delay_ff <= gen_delay;
      end
      if (push) begin
         rsp_kind_ff  <= pend_kind_ff;
         rsp_tag_ff   <= pend_tag_ff;
         rsp_bytes_ff <= pend_bytes_ff;
         rsp_delay_ff <= pend_delay_ff;
         rsp_last_ff  <= flush;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.kind          = rsp_kind_ff;
   assign rsp_bus.out_tag       = rsp_tag_ff;
   assign rsp_bus.packet_bytes  = rsp_bytes_ff;
   assign rsp_bus.wake_delay_ns = rsp_delay_ff;
   assign rsp_bus.last          = rsp_last_ff;
endmodule

// ===== sv/rate_limited_receive_queue_unit.sv =====
// Rate limited receive queue: leaky-bucket receive shaper with a descriptor queue.
// Usage:
//   req_bus carries one word per event: mode 0 is a packet arrival (payload
//   length, header size, tag), mode 1 is a wakeup event with now_time.
//   rsp_bus returns the words caused by that event: buffered or dropped, then
//   delivered packets in queue order, then at most one wakeup request; last
//   marks the final word of the event. A wakeup that delivers nothing and
//   leaves less than 1 ns of budget returns no word at all.
//   csr_bus writes the four configuration registers; it is ready out of reset.
// Timing:
//   One event at a time. Arrival: accept, admit, finish when no drain
//   follows. Wakeup: accept, elapsed time, subtract before draining. Each
//   delivered packet takes check, memory read with cost multiply and budget
//   add; the end check, wakeup request and finish close the event. A word
//   appears on rsp_bus in the cycle after the next word or the end is known.
//   The next event is accepted while the final word still waits.
// Reset clears queue pointers, counts, budget, flag and wake time, and loads
// register defaults. A stalled receiver holds the sequencer until its one
// pending word can move into the output register.
module rate_limited_receive_queue_unit #(
   parameter int QUEUE_DEPTH   = rlrq_pkg::QUEUE_DEPTH_DEF,
   parameter int FRACTION_BITS = rlrq_pkg::FRACTION_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   rlrq_req_if.sink    req_bus,
   rlrq_rsp_if.source  rsp_bus,
   rlrq_csr_if.sink    csr_bus
);
   import rlrq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   cfg_type         cfg_ff, cfg_in;
   logic            ram_we;
   logic [IDX_W-1:0] ram_waddr;
   desc_type        ram_wdata;
   logic            ram_re;
   logic [IDX_W-1:0] ram_raddr;
   desc_type        ram_rdata;
   budget_ctrl_type bctrl;
   budget_stat_type bstat;

   assign csr_bus.ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_CAPACITY:    cfg_in.buffer_capacity_bytes = CAP_W'(csr_bus.data);
            CSR_NS_PER_BYTE: cfg_in.ns_per_byte           = NPB_W'(csr_bus.data);
            CSR_BATCH_TIME:  cfg_in.batch_time_ns         = BATCH_W'(csr_bus.data);
            CSR_BOOTSTRAP:   cfg_in.bootstrap_mode        = csr_bus.data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_capacity_bytes <= CAP_RESET;
         cfg_ff.ns_per_byte           <= NPB_RESET;
         cfg_ff.batch_time_ns         <= BATCH_RESET;
         cfg_ff.bootstrap_mode        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rlrq_seq #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .capacity  (cfg_ff.buffer_capacity_bytes),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .bctrl     (bctrl),
      .bstat     (bstat)
   );

   rlrq_desc_ram #(
      .DEPTH(QUEUE_DEPTH),
      .WIDTH($bits(desc_type))
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rlrq_budget_unit #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_budget (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .ctrl  (bctrl),
      .stat  (bstat)
   );
endmodule

// ===== sv/rlrq_port_checker.sv =====
// Port-level checks of the receive queue, bound to the top level.
// Depends on rlrq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rlrq_port_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rlrq_pkg::KIND_W-1:0]  rsp_kind,
   input logic [rlrq_pkg::DELAY_W-1:0] rsp_wake_delay_ns,
   input logic                         rsp_last
);
   import rlrq_pkg::*;

   `RLRQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `RLRQ_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped")
   `RLRQ_ASSERT_IMPL(a_wake_last, clock, reset, rsp_valid && (rsp_kind == KIND_WAKEUP), (rsp_wake_delay_ns != '0) && rsp_last, "bad wakeup word")
   `RLRQ_ASSERT_IMPL(a_no_accept_midway, clock, reset, rsp_valid && !rsp_last, !req_ready, "accept before event done")
endmodule

bind rate_limited_receive_queue_unit rlrq_port_checker u_port_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_kind          (rsp_bus.kind),
   .rsp_wake_delay_ns (rsp_bus.wake_delay_ns),
   .rsp_last          (rsp_bus.last)
);

// ===== dv/rlrq_shaper_monitor.sv =====
`timescale 1ns / 100ps
// Response monitor of the rate limited receive queue: follows the request, response and
// register channels, predicts every response word and compares it field by field.
// Depends on rlrq_pkg and the channel interfaces of rlrq_if.sv.
module rlrq_shaper_monitor
   import rlrq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   rlrq_req_if  req_bus,
   rlrq_rsp_if  rsp_bus,
   rlrq_csr_if  csr_bus,
   output int   fail_count,
   output int   pending_words,
   output int   delivered_total,
   output int   dropped_total,
   output int   wakeup_total
);

   typedef struct packed {
      kind_type           kind;
      logic [TAG_W-1:0]   tag;
      logic [LEN_W-1:0]   bytes;
      logic [DELAY_W-1:0] delay;
      logic               last;
   } rsp_word_type;

   rsp_word_type      expected_words[$];
   desc_type          held_packets[QUEUE_DEPTH];
   int unsigned       head_slot;
   int unsigned       held_count;
   logic [CAP_W-1:0]  stored_bytes;
   logic [63:0]       budget;
   logic              receiving;
   logic [TIME_W-1:0] last_wake;
   cfg_type           settings;

   task automatic push_word(kind_type kind, logic [TAG_W-1:0] tag, logic [LEN_W-1:0] bytes,
                            logic [DELAY_W-1:0] delay);
      expected_words.push_back('{kind: kind, tag: tag, bytes: bytes, delay: delay, last: 1'b0});
      case (kind)
         KIND_DELIVERED: delivered_total++;
         KIND_DROPPED:   dropped_total++;
         KIND_WAKEUP:    wakeup_total++;
         default: ;
      endcase
   endtask

   task automatic drain_queue();
      logic [63:0]      limit;
      logic [63:0]      cost;
      logic [63:0]      room;
      logic [63:0]      whole;
      desc_type         d;
      logic [LEN_W-1:0] len;
      limit = 64'(settings.batch_time_ns) << FRACTION_BITS;
      while (held_count > 0 && budget <= limit) begin
         d = held_packets[head_slot];
         head_slot = (head_slot + 1) % QUEUE_DEPTH;
         held_count--;
         stored_bytes = (stored_bytes >= CAP_W'(d.pay)) ? stored_bytes - CAP_W'(d.pay) : '0;
         len = LEN_W'(d.pay) + LEN_W'(d.hdr);
         if (!settings.bootstrap_mode) begin
            cost = 64'(len) * 64'(settings.ns_per_byte);
            room = 64'(BUDGET_MAX) - budget;
            budget = (cost > room) ? 64'(BUDGET_MAX) : budget + cost;
         end
         push_word(KIND_DELIVERED, d.tag, len, '0);
      end
      whole = budget >> FRACTION_BITS;
      if (whole != 0) begin
         receiving = 1'b1;
         push_word(KIND_WAKEUP, '0, '0, (whole > 64'(WAKE_MAX)) ? WAKE_MAX : DELAY_W'(whole));
      end
   endtask

   task automatic predict_event();
      int unsigned      first_new;
      logic [CAP_W-1:0] free_bytes;
      logic [63:0]      elapsed;
      logic [63:0]      sub;
      first_new = expected_words.size();
      if (req_bus.mode == MODE_ARRIVAL) begin
         free_bytes = (settings.buffer_capacity_bytes > stored_bytes)
                      ? settings.buffer_capacity_bytes - stored_bytes : '0;
         if (held_count < QUEUE_DEPTH && CAP_W'(req_bus.payload_length) <= free_bytes) begin
            held_packets[(head_slot + held_count) % QUEUE_DEPTH] =
               '{tag: req_bus.packet_tag, hdr: req_bus.header_size, pay: req_bus.payload_length};
            held_count++;
            stored_bytes = stored_bytes + CAP_W'(req_bus.payload_length);
            push_word(KIND_BUFFERED, req_bus.packet_tag, '0, '0);
            if (!receiving) drain_queue();
         end else begin
            push_word(KIND_DROPPED, req_bus.packet_tag, '0, '0);
         end
      end else begin
         receiving = 1'b0;
         if (req_bus.now_time > last_wake) begin
            elapsed = 64'(req_bus.now_time - last_wake);
            if (elapsed > (64'(BUDGET_MAX) >> FRACTION_BITS)) begin
               budget = '0;
            end else begin
               sub = elapsed << FRACTION_BITS;
               budget = (budget > sub) ? budget - sub : '0;
            end
         end
         last_wake = req_bus.now_time;
         drain_queue();
      end
      if (expected_words.size() > first_new) expected_words[expected_words.size() - 1].last = 1'b1;
   endtask

   task automatic report_field(string field, logic [63:0] want, logic [63:0] got);
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
   endtask

   task automatic check_word();
      rsp_word_type want;
      if (expected_words.size() == 0) begin
         fail_count++;
         $display("%0t ns: word with nothing expected, kind %0d tag %0h", $time,
                  rsp_bus.kind, rsp_bus.out_tag);
         return;
      end
      want = expected_words.pop_front();
      if (rsp_bus.kind !== want.kind) report_field("kind", want.kind, rsp_bus.kind);
      if (rsp_bus.out_tag !== want.tag) report_field("out_tag", want.tag, rsp_bus.out_tag);
      if (rsp_bus.packet_bytes !== want.bytes)
         report_field("packet_bytes", want.bytes, rsp_bus.packet_bytes);
      if (rsp_bus.wake_delay_ns !== want.delay)
         report_field("wake_delay_ns", want.delay, rsp_bus.wake_delay_ns);
      if (rsp_bus.last !== want.last) report_field("last", want.last, rsp_bus.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         head_slot = 0;
         held_count = 0;
         stored_bytes = '0;
         budget = '0;
         receiving = 1'b0;
         last_wake = '0;
         settings = '{buffer_capacity_bytes: CAP_RESET, ns_per_byte: NPB_RESET,
                      batch_time_ns: BATCH_RESET, bootstrap_mode: 1'b0};
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_word();
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_index_type'(csr_bus.index))
               CSR_CAPACITY:    settings.buffer_capacity_bytes = csr_bus.data[CAP_W-1:0];
               CSR_NS_PER_BYTE: settings.ns_per_byte = csr_bus.data[NPB_W-1:0];
               CSR_BATCH_TIME:  settings.batch_time_ns = csr_bus.data[BATCH_W-1:0];
               CSR_BOOTSTRAP:   settings.bootstrap_mode = csr_bus.data[0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) predict_event();
      end
      pending_words = expected_words.size();
   end

endmodule

// ===== dv/rate_limited_receive_queue_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top of the rate limited receive queue: clock, reset, stimulus and verdict.
// Depends on rlrq_pkg, rlrq_if.sv, rate_limited_receive_queue_unit and rlrq_shaper_monitor.
module rate_limited_receive_queue_unit_tb;
   import rlrq_pkg::*;

   localparam int                RANDOM_EVENTS = 420;
   localparam int                PHASES        = 8;
   localparam int                LONG_HOLD     = 300;
   localparam int                SETTLE_CYCLES = 12;
   localparam logic [TIME_W-1:0] BIG_JUMP      = 48'h0800_0000_0000;

   logic clock = 1'b0;
   logic reset;

   rlrq_req_if req_bus();
   rlrq_rsp_if rsp_bus();
   rlrq_csr_if csr_bus();

   int fail_count, pending_words, delivered_total, dropped_total, wakeup_total;
   int event_total, setting_total, directed_total;

   logic [TIME_W-1:0] clock_ns;
   logic [NPB_W-1:0]  phase_npb;
   bit                calm;
   bit                hold_request;
   bit                sender_bursty;
   bit                receiver_bursty;

   rate_limited_receive_queue_unit u_dut (
      .clock,
      .reset,
      .req_bus,
      .rsp_bus,
      .csr_bus
   );

   rlrq_shaper_monitor u_monitor (
      .clock,
      .reset,
      .req_bus,
      .rsp_bus,
      .csr_bus,
      .fail_count,
      .pending_words,
      .delivered_total,
      .dropped_total,
      .wakeup_total
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("%0t ns: timeout, %0d words still expected", $time, pending_words);
      $display("simulation failed");
      $finish;
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int stall_left;
      int k;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            for (k = 0; k < LONG_HOLD; k++) @(negedge clock);
            hold_request = 1'b0;
         end
         if ($urandom_range(0, 63) == 0) receiver_bursty = !receiver_bursty;
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (!calm && receiver_bursty && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(logic mode, logic [PAY_W-1:0] pay, logic [HDR_W-1:0] hdr,
                            logic [TAG_W-1:0] tag, logic [TIME_W-1:0] now);
      req_bus.mode           <= mode;
      req_bus.payload_length <= pay;
      req_bus.header_size    <= hdr;
      req_bus.packet_tag     <= tag;
      req_bus.now_time       <= now;
      req_bus.valid          <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      event_total++;
   endtask

   task automatic send_arrival(logic [PAY_W-1:0] pay, logic [HDR_W-1:0] hdr,
                               logic [TAG_W-1:0] tag);
      send_word(MODE_ARRIVAL, pay, hdr, tag, TIME_W'({$urandom, $urandom}));
   endtask

   task automatic send_wakeup(logic [TIME_W-1:0] now);
      send_word(MODE_WAKEUP, PAY_W'($urandom), HDR_W'($urandom), TAG_W'($urandom), now);
   endtask

   task automatic maybe_idle();
      if ($urandom_range(0, 31) == 0) sender_bursty = !sender_bursty;
      if (!calm && sender_bursty && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // wait for every expected word, then for the tail of a silent event
   task automatic settle();
      int k;
      req_bus.valid <= 1'b0;
      for (k = 0; k < 100000 && pending_words != 0; k++) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
   endtask

   task automatic load_settings(logic [CAP_W-1:0] cap, logic [NPB_W-1:0] npb,
                                logic [BATCH_W-1:0] batch, logic boot);
      write_register(CSR_CAPACITY, CSR_DATA_W'(cap));
      write_register(CSR_NS_PER_BYTE, CSR_DATA_W'(npb));
      write_register(CSR_BATCH_TIME, CSR_DATA_W'(batch));
      write_register(CSR_BOOTSTRAP, CSR_DATA_W'(boot));
      csr_bus.valid <= 1'b0;
      phase_npb = npb;
      setting_total++;
   endtask

   function automatic logic [PAY_W-1:0] pick_payload();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return PAY_W'($urandom);
         default: return PAY_W'($urandom_range(1, 1500));
      endcase
   endfunction

   // time steps roughly follow the receive cost of the current setting
   function automatic logic [TIME_W-1:0] next_wake_time();
      logic [63:0] step_max;
      step_max = ((64'(phase_npb) >> 16) + 1) * 3000;
      case ($urandom_range(0, 19))
         0:       clock_ns = clock_ns + BIG_JUMP + TIME_W'($urandom);
         1:       clock_ns = clock_ns - TIME_W'($urandom_range(0, 100000));
         2:       ;
         3:       clock_ns = TIME_W'({$urandom, $urandom});
         default: clock_ns = clock_ns + TIME_W'({$urandom, $urandom} % (step_max + 1));
      endcase
      return clock_ns;
   endfunction

   initial begin
      int               phase;
      int               burst;
      bit               hold_done;
      logic [CAP_W-1:0] cap;
      logic [NPB_W-1:0] npb;
      logic [BATCH_W-1:0] batch;
      logic             boot;

      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.mode           = MODE_ARRIVAL;
      req_bus.payload_length = '0;
      req_bus.header_size    = '0;
      req_bus.packet_tag     = '0;
      req_bus.now_time       = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = CSR_CAPACITY;
      csr_bus.data           = '0;
      clock_ns               = '0;
      phase_npb              = NPB_RESET;
      hold_done              = 1'b0;
      sender_bursty          = 1'b1;
      receiver_bursty        = 1'b1;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: limits of the fields, drops, receiving state, time corner cases
      send_arrival('0, '0, 16'h0000);
      send_arrival(16'hFFFF, 8'hFF, 16'hFFFF);
      send_arrival(16'd1, 8'd0, 16'h1234);
      send_arrival(16'hFFFF, 8'hFF, 16'hA5A5);
      send_arrival(16'd1, 8'd0, 16'h5A5A);
      send_arrival(16'd0, 8'd0, 16'h0F0F);
      send_wakeup('0);
      send_wakeup('1);
      send_arrival(16'd100, 8'd20, 16'h3C3C);
      settle();
      load_settings('0, '1, '0, 1'b0);
      send_arrival(16'd0, 8'hFF, 16'h8001);
      send_arrival(16'd1, 8'd0, 16'h8002);
      clock_ns = 48'd1000;
      send_wakeup(clock_ns);
      clock_ns = clock_ns + BIG_JUMP;
      send_wakeup(clock_ns);
      clock_ns = clock_ns + BIG_JUMP;
      send_wakeup(clock_ns);
      clock_ns = clock_ns + BIG_JUMP;
      send_wakeup(clock_ns);
      settle();
      load_settings(21'd1048576, '0, '1, 1'b1);
      send_arrival(16'hFFFF, 8'hFF, 16'h7FFE);
      send_wakeup(48'hAAAA_AAAA_AAAA);
      send_wakeup(48'h5555_5555_5555);
      send_arrival(16'hAAAA, 8'hAA, 16'h5555);
      send_arrival(16'h5555, 8'h55, 16'hAAAA);
      clock_ns = 48'h5555_5555_5555;
      directed_total = event_total;

      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: begin
               cap = 21'd1048576; npb = '1; batch = '1; boot = 1'b0;
            end
            1: begin
               cap = '0; npb = '0; batch = '0; boot = 1'b0;
            end
            PHASES - 1: begin
               cap = CAP_RESET; npb = NPB_RESET; batch = BATCH_RESET; boot = 1'b0;
            end
            default: begin
               case ($urandom_range(0, 4))
                  0:       cap = '0;
                  1:       cap = 21'd1048576;
                  2:       cap = CAP_RESET;
                  3:       cap = CAP_W'($urandom_range(1, 4096));
                  default: cap = CAP_W'($urandom_range(0, 1048576));
               endcase
               case ($urandom_range(0, 5))
                  0:       npb = '0;
                  1:       npb = '1;
                  2:       npb = NPB_RESET;
                  3:       npb = NPB_W'($urandom_range(0, 1 << 20));
                  4:       npb = NPB_W'({$urandom, $urandom});
                  default: npb = NPB_W'($urandom_range(1 << 12, 1 << 18));
               endcase
               case ($urandom_range(0, 4))
                  0:       batch = '0;
                  1:       batch = '1;
                  2:       batch = BATCH_RESET;
                  3:       batch = BATCH_W'($urandom);
                  default: batch = BATCH_W'($urandom_range(0, 100000));
               endcase
               boot = ($urandom_range(0, 4) == 0);
            end
         endcase
         load_settings(cap, npb, batch, boot);
         if (phase == PHASES - 1) calm = 1'b1;

         while (event_total < directed_total + (phase + 1) * (RANDOM_EVENTS / PHASES)) begin
            if (phase == 3 && !hold_done &&
                event_total > directed_total + 3 * (RANDOM_EVENTS / PHASES) + 10) begin
               hold_request = 1'b1;
               hold_done    = 1'b1;
            end
            if ($urandom_range(0, 4) != 0) begin
               // a run of arrivals, long ones fill the queue, then wakeups
               burst = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 40)
                                                   : $urandom_range(1, 6);
               repeat (burst) begin
                  maybe_idle();
                  send_arrival(pick_payload(), HDR_W'($urandom), TAG_W'($urandom));
               end
               repeat ($urandom_range(1, 3)) begin
                  maybe_idle();
                  send_wakeup(next_wake_time());
               end
            end else begin
               maybe_idle();
               if ($urandom_range(0, 1) == 0) begin
                  send_arrival(PAY_W'($urandom), HDR_W'($urandom), TAG_W'($urandom));
               end else begin
                  clock_ns = TIME_W'({$urandom, $urandom});
                  send_wakeup(clock_ns);
               end
            end
         end
      end

      settle();
      $display("Run covered %0d events under %0d register settings.", event_total,
               setting_total);
      $display("Predicted %0d deliveries, %0d drops and %0d wakeup requests.",
               delivered_total, dropped_total, wakeup_total);
      if (fail_count == 0 && pending_words == 0) begin
         $display("simulation ok");
      end else begin
         if (pending_words != 0)
            $display("%0t ns: %0d expected words never arrived", $time, pending_words);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rlrq_pkg.sv
sv/rlrq_if.sv
sv/rlrq_desc_ram.sv
sv/rlrq_budget_unit.sv
sv/rlrq_seq.sv
sv/rate_limited_receive_queue_unit.sv
sv/rlrq_port_checker.sv
dv/rlrq_shaper_monitor.sv
dv/rate_limited_receive_queue_unit_tb.sv
